[rtl/fdmd_pkg.sv]
// ----------------------------------------------------------------------------
// fdmd_pkg
// Shared types and constants of the frame difference motion detector.
// ----------------------------------------------------------------------------
package fdmd_pkg;

    // Frame store geometry
    localparam int MAX_PIXELS = 2097152;
    localparam int IDX_W      = $clog2(MAX_PIXELS);
    localparam int IDX_CNT_W  = IDX_W + 1;

    // Field widths
    localparam int LUMA_W  = 8;
    localparam int DIM_W   = 13;
    localparam int TIME_W  = 48;
    localparam int PCNT_W  = 22;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * DIM_W;
    localparam int EVAL_W  = PCNT_W + FRAC_W;

    // Event queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0]        CAMERA_NUMBER_RST      = 8'd0;
    localparam logic [FRAC_W-1:0] MOTION_FRACTION_RST    = 16'd3277;
    localparam logic [7:0]        PIXEL_CHANGE_LEVEL_RST = 8'd20;

    typedef enum logic [1:0] {
        REG_CAMERA_NUMBER      = 2'd0,
        REG_MOTION_FRACTION    = 2'd1,
        REG_PIXEL_CHANGE_LEVEL = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]        camera_number;
        logic [FRAC_W-1:0] motion_fraction;
        logic [7:0]        pixel_change_level;
    } t_cfg;

    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [TIME_W-1:0] frame_time;
        logic              end_of_frame;
    } t_pixel;

    typedef struct packed {
        logic [7:0]        event_camera;
        logic [PCNT_W-1:0] changed_count;
        logic [PCNT_W-1:0] pixel_total;
        logic [TIME_W-1:0] event_time;
    } t_event;

endpackage

[rtl/fdmd_ram.sv]
// ----------------------------------------------------------------------------
// fdmd_ram
// Generic single-clock RAM, one write port and one read port, registered
// read. A read and a write of the same entry in one cycle return old data.
// ----------------------------------------------------------------------------
module fdmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fdmd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fdmd_cfg_regs
// APB register bank: camera number, motion fraction, pixel change level.
// ----------------------------------------------------------------------------
module fdmd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fdmd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fdmd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fdmd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output fdmd_pkg::t_cfg                    o_cfg
);
    import fdmd_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_CAMERA_NUMBER:      n_cfg.camera_number      = pwdata[7:0];
                REG_MOTION_FRACTION:    n_cfg.motion_fraction    = pwdata[FRAC_W-1:0];
                REG_PIXEL_CHANGE_LEVEL: n_cfg.pixel_change_level = pwdata[7:0];
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.camera_number      <= CAMERA_NUMBER_RST;
            r_cfg.motion_fraction    <= MOTION_FRACTION_RST;
            r_cfg.pixel_change_level <= PIXEL_CHANGE_LEVEL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_CAMERA_NUMBER:      prdata = APB_DATA_W'(r_cfg.camera_number);
            REG_MOTION_FRACTION:    prdata = APB_DATA_W'(r_cfg.motion_fraction);
            REG_PIXEL_CHANGE_LEVEL: prdata = APB_DATA_W'(r_cfg.pixel_change_level);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/fdmd_evt_fifo.sv]
// ----------------------------------------------------------------------------
// fdmd_evt_fifo
// Small queue of motion events between the evaluation pipeline and the
// output channel.
// ----------------------------------------------------------------------------
module fdmd_evt_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  fdmd_pkg::t_event                i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output fdmd_pkg::t_event                o_data,
    output logic [fdmd_pkg::FIFO_CNT_W-1:0] o_count
);
    import fdmd_pkg::*;

    t_event                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_CNT_W-1:0] n_count;
    logic                  w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + FIFO_CNT_W'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

[rtl/frame_difference_motion_detector.sv]
// ----------------------------------------------------------------------------
// frame_difference_motion_detector
// Compares each luma pixel with the same pixel of the previous frame and
// raises a motion event at end of frame when enough pixels changed.
// ----------------------------------------------------------------------------
// Takes one pixel per clock. Each pixel reads and rewrites its entry of the
// frame store in its accept cycle (the RAM returns the old value), so the
// store's single write port and single read port set the rate of one pixel
// a cycle. An event passes stages 1, 2 and 3 after its end-of-frame
// pixel is accepted, then waits in a four-entry queue; input ready drops only
// while queued events plus end-of-frame pixels still in flight fill those
// four slots. The frame store has no clearing pass: after reset it is
// undefined until the first frame has written it, and the first frame is
// never compared.
module frame_difference_motion_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel channel
    input  logic                            i_pix_valid,
    output logic                            o_pix_ready,
    input  fdmd_pkg::t_pixel                i_pix,
    // event channel
    output logic                            o_evt_valid,
    input  logic                            i_evt_ready,
    output fdmd_pkg::t_event                o_evt,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fdmd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fdmd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fdmd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import fdmd_pkg::*;

    t_cfg w_cfg;

    // stage 0: accept, store access, frame bookkeeping
    logic                 w_acc;
    logic [PROD_W-1:0]    w_total0;
    logic                 w_fits0;
    logic                 w_same0;
    logic                 w_in_store;
    logic [IDX_CNT_W-1:0] r_idx;
    logic [IDX_CNT_W-1:0] n_idx;
    logic                 r_store_valid;
    logic [DIM_W-1:0]     r_stored_w;
    logic [DIM_W-1:0]     r_stored_h;
    logic [LUMA_W-1:0]    w_prev;

    // stage 1: compare, tally
    logic                 r_s1_v;
    logic                 r_s1_eof;
    logic                 r_s1_same;
    logic [LUMA_W-1:0]    r_s1_luma;
    logic [IDX_CNT_W-1:0] r_s1_idx;
    logic [PROD_W-1:0]    r_s1_total;
    logic [TIME_W-1:0]    r_s1_time;
    logic                 w_cmp;
    logic [LUMA_W-1:0]    w_diff;
    logic                 w_changed;
    logic [PCNT_W-1:0]    r_tally;
    logic [PCNT_W-1:0]    w_tally_inc;

    // stage 2: threshold product
    logic                 r_s2_v;
    logic [PCNT_W-1:0]    r_s2_count;
    logic [PCNT_W-1:0]    r_s2_total;
    logic [TIME_W-1:0]    r_s2_time;

    // stage 3: decision
    logic                 r_s3_v;
    logic [PCNT_W-1:0]    r_s3_count;
    logic [PCNT_W-1:0]    r_s3_total;
    logic [TIME_W-1:0]    r_s3_time;
    logic [EVAL_W-1:0]    r_s3_limit;
    logic                 w_hit;
    t_event               w_evt;

    logic [FIFO_CNT_W-1:0] w_fifo_cnt;
    logic [1:0]            w_inflight;
    logic [FIFO_CNT_W:0]   w_credit_used;

    fdmd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Reserve a queue slot for every end-of-frame pixel still in the pipe.
    assign w_inflight    = 2'(r_s1_v && r_s1_eof) + 2'(r_s2_v) + 2'(r_s3_v);
    assign w_credit_used = (FIFO_CNT_W + 1)'(w_fifo_cnt) + (FIFO_CNT_W + 1)'(w_inflight);
    assign o_pix_ready   = w_credit_used < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
    assign w_acc         = i_pix_valid && o_pix_ready;

    assign w_total0   = PROD_W'(i_pix.frame_width) * PROD_W'(i_pix.frame_height);
    assign w_fits0    = (w_total0 != '0) && (w_total0 <= PROD_W'(MAX_PIXELS));
    // A valid store always holds a frame that fit, so equal dimensions fit too.
    assign w_same0    = r_store_valid && (r_stored_w == i_pix.frame_width)
                        && (r_stored_h == i_pix.frame_height);
    assign w_in_store = r_idx < IDX_CNT_W'(MAX_PIXELS);

    fdmd_ram #(
        .WIDTH (LUMA_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_acc && w_in_store),
        .i_waddr (r_idx[IDX_W-1:0]),
        .i_wdata (i_pix.luma),
        .i_re    (w_acc),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_prev)
    );

    always_comb begin
        n_idx = r_idx;
        if (w_acc) begin
            if (i_pix.end_of_frame) begin
                n_idx = '0;
            end else if (w_in_store) begin
                n_idx = r_idx + IDX_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx         <= '0;
            r_store_valid <= 1'b0;
            r_stored_w    <= '0;
            r_stored_h    <= '0;
            r_s1_v        <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_s1_v <= w_acc;
            if (w_acc && i_pix.end_of_frame) begin
                r_store_valid <= w_fits0;
                r_stored_w    <= i_pix.frame_width;
                r_stored_h    <= i_pix.frame_height;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_eof   <= i_pix.end_of_frame;
            r_s1_same  <= w_same0;
            r_s1_luma  <= i_pix.luma;
            r_s1_idx   <= r_idx;
            r_s1_total <= w_total0;
            r_s1_time  <= i_pix.frame_time;
        end
    end

    // stage 1
    assign w_cmp       = r_s1_same && (PROD_W'(r_s1_idx) < r_s1_total);
    assign w_diff      = (r_s1_luma > w_prev) ? (r_s1_luma - w_prev) : (w_prev - r_s1_luma);
    assign w_changed   = w_cmp && (w_diff > w_cfg.pixel_change_level);
    assign w_tally_inc = r_tally + PCNT_W'(w_changed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
        end else begin
            if (r_s1_v) begin
                r_tally <= r_s1_eof ? '0 : w_tally_inc;
            end
            // Only a frame matching the stored one can raise an event.
            r_s2_v <= r_s1_v && r_s1_eof && r_s1_same;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_count <= w_tally_inc;
        r_s2_total <= r_s1_total[PCNT_W-1:0];
        r_s2_time  <= r_s1_time;
        r_s3_count <= r_s2_count;
        r_s3_total <= r_s2_total;
        r_s3_time  <= r_s2_time;
        r_s3_limit <= EVAL_W'(w_cfg.motion_fraction) * EVAL_W'(r_s2_total);
    end

    // stage 3: changed * 2^16 > fraction * total
    assign w_hit = r_s3_v && ({r_s3_count, {FRAC_W{1'b0}}} > r_s3_limit);

    always_comb begin
        w_evt.event_camera  = w_cfg.camera_number;
        w_evt.changed_count = r_s3_count;
        w_evt.pixel_total   = r_s3_total;
        w_evt.event_time    = r_s3_time;
    end

    fdmd_evt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_hit),
        .i_data  (w_evt),
        .o_valid (o_evt_valid),
        .i_ready (i_evt_ready),
        .o_data  (o_evt),
        .o_count (w_fifo_cnt)
    );

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_credit_used <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
        else $error("event queue credit overrun");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_CNT_W'(MAX_PIXELS))
        else $error("pixel index beyond frame store");

    a_eof_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_pix.end_of_frame |=> r_idx == '0 && r_s1_v && r_s1_eof)
        else $error("end of frame did not restart pixel index");

    a_event_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v |-> $past(r_s2_v))
        else $error("decision stage without a finished frame");

endmodule

[dv/frame_difference_motion_detector_tb.sv]
// ----------------------------------------------------------------------------
// frame_difference_motion_detector_tb
// Streams luma frames through the motion detector and checks every motion
// event against a predictor that keeps its own copy of the frame store. The
// run covers directed corner cases, threshold and register extremes, large
// frame dimensions, and a long random stream with idle gaps on both channels.
// ----------------------------------------------------------------------------
module frame_difference_motion_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fdmd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SHOW_LIMIT     = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_pix_valid;
    logic                  o_pix_ready;
    t_pixel                i_pix;
    logic                  o_evt_valid;
    logic                  i_evt_ready;
    t_event                o_evt;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor copy of the detector state
    bit [7:0]    prior_luma [MAX_PIXELS];
    bit          prior_ok;
    bit [12:0]   prior_w;
    bit [12:0]   prior_h;
    int unsigned pix_pos;
    int unsigned changed_run;
    int unsigned written_top;
    bit [7:0]    cfg_camera;
    bit [15:0]   cfg_fraction;
    bit [7:0]    cfg_level;
    t_event      motion_due [$];

    int unsigned pixels_sent;
    int          fail_count;
    int          shown_count;
    int          stall_cycles;
    int          evt_hold;
    bit          pix_steady;
    bit          evt_steady;
    int unsigned change_mix [5] = '{0, 5, 30, 70, 100};

    frame_difference_motion_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_pix       (i_pix),
        .o_evt_valid (o_evt_valid),
        .i_evt_ready (i_evt_ready),
        .o_evt       (o_evt),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit matches_store(input t_pixel p);
        longint unsigned area;
        area = 64'(p.frame_width) * 64'(p.frame_height);
        return prior_ok && prior_w == p.frame_width && prior_h == p.frame_height
            && area >= 1 && area <= MAX_PIXELS;
    endfunction

    // advance the predictor by one accepted pixel
    function automatic void model_pixel(input t_pixel p);
        longint unsigned area;
        bit              same;
        bit [7:0]        old;
        int unsigned     delta;
        t_event          ev;
        area = 64'(p.frame_width) * 64'(p.frame_height);
        same = matches_store(p);
        if (same && pix_pos < area) begin
            old   = prior_luma[pix_pos];
            delta = (p.luma > old) ? 32'(p.luma - old) : 32'(old - p.luma);
            if (delta > cfg_level) changed_run++;
        end
        if (pix_pos < MAX_PIXELS) begin
            prior_luma[pix_pos] = p.luma;
            pix_pos++;
            if (pix_pos > written_top) written_top = pix_pos;
        end
        if (p.end_of_frame) begin
            if (same && 64'(changed_run) * 64'd65536 > 64'(cfg_fraction) * area) begin
                ev.event_camera  = cfg_camera;
                ev.changed_count = changed_run[PCNT_W-1:0];
                ev.pixel_total   = area[PCNT_W-1:0];
                ev.event_time    = p.frame_time;
                motion_due.push_back(ev);
            end
            prior_ok    = (area >= 1 && area <= MAX_PIXELS);
            prior_w     = p.frame_width;
            prior_h     = p.frame_height;
            pix_pos     = 0;
            changed_run = 0;
        end
    endfunction

    function automatic string event_text(input t_event e);
        return $sformatf("cam %0d changed %0d total %0d time %0h",
                         e.event_camera, e.changed_count, e.pixel_total, e.event_time);
    endfunction

    function automatic bit [7:0] shifted_luma(input bit [7:0] base, input int unsigned d);
        if ($urandom_range(0, 1) == 1 && base >= d) return 8'(base - d);
        if (base + d <= 255) return 8'(base + d);
        if (base >= d) return 8'(base - d);
        return 8'($urandom);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_pixel(input t_pixel p);
        int gap;
        gap = pix_steady ? 0 : $urandom_range(0, 5);
        // steer clear of store entries that were never written since reset
        if (matches_store(p) && pix_pos >= written_top
            && 64'(pix_pos) < 64'(p.frame_width) * 64'(p.frame_height))
            p.frame_width = prior_w ^ 13'd1;
        if (gap > 0) begin
            i_pix_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_pix_valid <= 1'b1;
        i_pix       <= p;
        @(posedge i_clk);
        while (o_pix_ready !== 1'b1) @(posedge i_clk);
        model_pixel(p);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_sample(input bit [7:0] luma, input bit [12:0] w, input bit [12:0] h,
                               input bit [47:0] stamp, input bit eof);
        t_pixel p;
        p.luma         = luma;
        p.frame_width  = w;
        p.frame_height = h;
        p.frame_time   = stamp;
        p.end_of_frame = eof;
        send_pixel(p);
    endtask

    // one frame in raster order; pct sets how many pixels are pushed past the level
    task automatic send_frame(input bit [12:0] w, input bit [12:0] h, input int unsigned len,
                              input int unsigned pct, input bit glitch);
        t_pixel          p;
        t_pixel          q;
        longint unsigned area;
        bit [7:0]        base;
        area           = 64'(w) * 64'(h);
        p.frame_width  = w;
        p.frame_height = h;
        p.frame_time   = 48'({$urandom, $urandom});
        if (matches_store(p) && ((len < area) ? len : area) > written_top)
            len = written_top;
        for (int unsigned i = 0; i < len; i++) begin
            base = prior_luma[i];
            if ($urandom_range(0, 7) == 0)
                p.luma = 8'($urandom);
            else if ($urandom_range(1, 100) <= pct)
                p.luma = shifted_luma(base, cfg_level + 1 + $urandom_range(0, 10));
            else
                p.luma = shifted_luma(base, $urandom_range(0, cfg_level));
            p.end_of_frame = (i == len - 1);
            q = p;
            if (glitch && $urandom_range(0, 5) == 0) begin
                q.frame_width  = 13'($urandom);
                q.frame_height = 13'($urandom);
            end
            send_pixel(q);
        end
    endtask

    task automatic send_noise(input int unsigned n);
        t_pixel p;
        for (int unsigned i = 0; i < n; i++) begin
            p.luma         = 8'($urandom);
            p.frame_width  = 13'($urandom);
            p.frame_height = 13'($urandom);
            p.frame_time   = 48'({$urandom, $urandom});
            p.end_of_frame = (i == n - 1);
            send_pixel(p);
        end
    endtask

    // drop valid, wait for all events, then let in-flight pixels retire
    task automatic drain();
        i_pix_valid <= 1'b0;
        while (motion_due.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        case (idx)
            REG_CAMERA_NUMBER:      cfg_camera   = value[7:0];
            REG_MOTION_FRACTION:    cfg_fraction = value[15:0];
            REG_PIXEL_CHANGE_LEVEL: cfg_level    = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input bit [7:0] camera, input bit [15:0] fraction,
                              input bit [7:0] level);
        drain();
        write_reg(REG_CAMERA_NUMBER, 32'(camera));
        write_reg(REG_MOTION_FRACTION, 32'(fraction));
        write_reg(REG_PIXEL_CHANGE_LEVEL, 32'(level));
    endtask

    // reset settings: camera 0, fraction 3277, level 20
    task automatic test_directed_cases();
        // first frame only fills the store
        send_sample(8'd0, 13'd2, 13'd2, 48'd0, 1'b0);
        send_sample(8'd255, 13'd2, 13'd2, 48'd0, 1'b0);
        send_sample(8'd0, 13'd2, 13'd2, 48'd0, 1'b0);
        send_sample(8'd255, 13'd2, 13'd2, 48'd0, 1'b1);
        // difference equal to the level does not count
        send_sample(8'd255, 13'd2, 13'd2, '1, 1'b0);
        send_sample(8'd0, 13'd2, 13'd2, '1, 1'b0);
        send_sample(8'd20, 13'd2, 13'd2, '1, 1'b0);
        send_sample(8'd255, 13'd2, 13'd2, '1, 1'b1);
        // one pixel just past the level
        send_sample(8'd255, 13'd2, 13'd2, 48'd77, 1'b0);
        send_sample(8'd0, 13'd2, 13'd2, 48'd77, 1'b0);
        send_sample(8'd41, 13'd2, 13'd2, 48'd77, 1'b0);
        send_sample(8'd255, 13'd2, 13'd2, 48'd77, 1'b1);
        // zero width frame invalidates the store
        send_sample(8'd9, 13'd0, 13'd5, 48'd1, 1'b1);
        // oversize frame is never compared
        send_sample(8'd3, 13'd4096, 13'd4096, 48'd2, 1'b0);
        send_sample(8'd250, 13'd4096, 13'd4096, 48'd2, 1'b1);
        // short frame at the widest line still validates the store
        send_sample(8'd0, 13'h1FFF, 13'd1, 48'd3, 1'b1);
        send_sample(8'd200, 13'h1FFF, 13'd1, 48'd4, 1'b0);
        send_sample(8'd0, 13'h1FFF, 13'd1, 48'd4, 1'b0);
        send_sample(8'd255, 13'h1FFF, 13'd1, 48'd4, 1'b1);
        // long frame: pixels past width*height are not compared
        send_sample(8'd10, 13'd1, 13'd2, 48'd5, 1'b0);
        send_sample(8'd10, 13'd1, 13'd2, 48'd5, 1'b1);
        send_sample(8'd100, 13'd1, 13'd2, 48'h8000_0000_0000, 1'b0);
        send_sample(8'd10, 13'd1, 13'd2, 48'h8000_0000_0000, 1'b0);
        send_sample(8'd77, 13'd1, 13'd2, 48'h8000_0000_0000, 1'b0);
        send_sample(8'd77, 13'd1, 13'd2, 48'h8000_0000_0000, 1'b1);
    endtask

    task automatic test_threshold_extremes();
        set_config(8'hFF, 16'd0, 8'd0);
        send_frame(13'd3, 13'd3, 9, 100, 1'b0);
        send_frame(13'd3, 13'd3, 9, 0, 1'b0);
        send_frame(13'd3, 13'd3, 9, 100, 1'b0);
        send_frame(13'd1, 13'd1, 1, 100, 1'b0);
        send_frame(13'd1, 13'd1, 1, 100, 1'b0);
        // full scale fraction needs every pixel changed
        set_config(8'h5A, 16'hFFFF, 8'd0);
        send_frame(13'd3, 13'd3, 9, 100, 1'b0);
        send_frame(13'd3, 13'd3, 9, 70, 1'b0);
        send_frame(13'd3, 13'd3, 9, 100, 1'b0);
        // top level: no difference can exceed it
        set_config(8'hA5, 16'hFFFF, 8'hFF);
        send_frame(13'd2, 13'd2, 4, 100, 1'b0);
        send_frame(13'd2, 13'd2, 4, 100, 1'b0);
        set_config(8'd1, 16'd3277, 8'd254);
        send_frame(13'd2, 13'd2, 4, 100, 1'b0);
        send_frame(13'd2, 13'd2, 4, 100, 1'b0);
    endtask

    // short frame pairs with large dimensions reach the upper bits of pixel_total
    task automatic test_large_frames();
        bit [12:0]   w;
        bit [12:0]   h;
        int unsigned hmax;
        set_config(8'($urandom), 16'd0, 8'($urandom_range(0, 30)));
        for (int k = 0; k < 8; k++) begin
            if (k == 0) begin
                w = 13'd2048;
                h = 13'd1024;
            end else if (k == 1) begin
                w = 13'd4096;
                h = 13'd4096;
            end else begin
                w    = 13'($urandom_range(1, 4096));
                hmax = MAX_PIXELS / w;
                if (hmax > 4096) hmax = 4096;
                h    = 13'($urandom_range(1, hmax));
            end
            send_frame(w, h, $urandom_range(2, 5), 50, 1'b0);
            send_frame(w, h, $urandom_range(2, 5), 100, 1'b0);
        end
    endtask

    task automatic test_random_traffic();
        int unsigned stop_at;
        int unsigned phase_end;
        int unsigned len;
        int unsigned area;
        int          pick;
        bit [12:0]   w;
        bit [12:0]   h;
        bit [15:0]   fraction;
        bit [7:0]    level;
        w         = 13'd4;
        h         = 13'd3;
        stop_at   = pixels_sent + 800;
        phase_end = pixels_sent;
        while (pixels_sent < stop_at) begin
            if (pixels_sent >= phase_end) begin
                case ($urandom_range(0, 3))
                    0:       fraction = 16'd0;
                    1:       fraction = 16'hFFFF;
                    default: fraction = 16'($urandom_range(0, 40000));
                endcase
                case ($urandom_range(0, 4))
                    0:       level = 8'd0;
                    1:       level = 8'hFF;
                    default: level = 8'($urandom_range(0, 60));
                endcase
                set_config(8'($urandom), fraction, level);
                pix_steady = ($urandom_range(0, 3) == 0);
                evt_steady = ($urandom_range(0, 3) == 0);
                phase_end  = pixels_sent + $urandom_range(100, 200);
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_noise($urandom_range(1, 3));
            end else begin
                if (pick <= 2) begin
                    w = 13'($urandom_range(1, 8));
                    h = 13'($urandom_range(1, 8));
                end
                area = 32'(w) * 32'(h);
                case ($urandom_range(0, 6))
                    0:       len = (area > 1) ? $urandom_range(1, area - 1) : 1;
                    1:       len = area + $urandom_range(1, 3);
                    default: len = area;
                endcase
                send_frame(w, h, len, change_mix[$urandom_range(0, 4)], pick == 19);
            end
        end
    endtask

    // event sink: hold ready low for the drawn number of cycles after each event
    always @(negedge i_clk) begin
        if (evt_hold > 0) begin
            i_evt_ready <= 1'b0;
            evt_hold--;
        end else begin
            i_evt_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && o_evt_valid === 1'b1 && i_evt_ready === 1'b1) begin
            evt_hold = evt_steady ? 0 : $urandom_range(0, 5);
            if (motion_due.size() == 0) begin
                fail_count++;
                if (shown_count < SHOW_LIMIT) begin
                    shown_count++;
                    $display("unexpected motion event: %s", event_text(o_evt));
                end
            end else begin
                want = motion_due.pop_front();
                if (o_evt.event_camera !== want.event_camera
                    || o_evt.changed_count !== want.changed_count
                    || o_evt.pixel_total !== want.pixel_total
                    || o_evt.event_time !== want.event_time) begin
                    fail_count++;
                    if (shown_count < SHOW_LIMIT) begin
                        shown_count++;
                        $display("motion event mismatch: expected %s", event_text(want));
                        $display("                       actual   %s", event_text(o_evt));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_pix_valid === 1'b1 && o_pix_ready === 1'b1)
            || (o_evt_valid === 1'b1 && i_evt_ready === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_pix_valid  = 1'b0;
        i_pix        = '0;
        i_evt_ready  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        prior_ok     = 1'b0;
        prior_w      = '0;
        prior_h      = '0;
        pix_pos      = 0;
        changed_run  = 0;
        written_top  = 0;
        cfg_camera   = CAMERA_NUMBER_RST;
        cfg_fraction = MOTION_FRACTION_RST;
        cfg_level    = PIXEL_CHANGE_LEVEL_RST;
        pixels_sent  = 0;
        fail_count   = 0;
        shown_count  = 0;
        stall_cycles = 0;
        evt_hold     = 0;
        pix_steady   = 1'b0;
        evt_steady   = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_threshold_extremes();
        test_large_frames();
        test_random_traffic();
        drain();

        if (motion_due.size() != 0) begin
            $display("%0d motion events never arrived", motion_due.size());
            fail_count += motion_due.size();
        end
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
